// ===== sv/xpr_pkg.sv =====
// Shared types, codes and the CRC step for the XMODEM receiver.
`default_nettype none
package xpr_pkg;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_ABORT = 2'd2;
  localparam logic [1:0] MODE_START = 2'd3;

  localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd0;
  localparam logic [1:0] CFG_CRC_ATTEMPTS   = 2'd1;
  localparam logic [1:0] CFG_START_ATTEMPTS = 2'd2;

  localparam logic [15:0] TIMEOUT_TICKS_RESET  = 16'd300;
  localparam logic [3:0]  CRC_ATTEMPTS_RESET   = 4'd4;
  localparam logic [3:0]  START_ATTEMPTS_RESET = 4'd12;

  localparam logic [3:0] ST_NONE        = 4'd0;
  localparam logic [3:0] ST_GOOD        = 4'd1;
  localparam logic [3:0] ST_BAD_SEQ     = 4'd2;
  localparam logic [3:0] ST_BAD_COMPL   = 4'd3;
  localparam logic [3:0] ST_BAD_CRC     = 4'd4;
  localparam logic [3:0] ST_BAD_SUM     = 4'd5;
  localparam logic [3:0] ST_PKT_TIMEOUT = 4'd6;
  localparam logic [3:0] ST_HDR_TIMEOUT = 4'd7;
  localparam logic [3:0] ST_FINISHED    = 4'd8;
  localparam logic [3:0] ST_GAVE_UP     = 4'd9;
  localparam logic [3:0] ST_ABORTED     = 4'd10;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_TX      = 1'b1;

  localparam int XPR_QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  // One or two results caused by one item; a second result is always transmitted.
  typedef struct packed {
    logic       two;
    logic       kind0;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [3:0] status;
  } grp_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/xpr_front.sv =====
// Front part: takes items and configuration, runs the protocol state, emits result groups.
`default_nettype none
module xpr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    mode,
  input  wire logic [7:0]    data_byte,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output logic               push_valid,
  input  wire logic          push_ready,
  output xpr_pkg::grp_t      push_grp
);
  import xpr_pkg::*;

  logic [15:0] timeout_ticks;
  logic [3:0]  crc_attempts;
  logic [3:0]  start_attempts;

  phase_t      phase, phase_next;
  logic [7:0]  expected_sequence, expected_sequence_next;
  logic        crc_mode, crc_mode_next;
  logic [3:0]  start_count, start_count_next;
  logic [10:0] byte_position, byte_position_next;
  logic        large_packet, large_packet_next;
  logic [15:0] crc_accumulator, crc_accumulator_next;
  logic [7:0]  sum_accumulator, sum_accumulator_next;
  logic [7:0]  received_sequence, received_sequence_next;
  logic [7:0]  received_crc_high, received_crc_high_next;
  logic [15:0] tick_counter, tick_counter_next;
  logic        in_start_phase, in_start_phase_next;
  logic        complement_bad, complement_bad_next;

  logic        emit;
  grp_t        grp;
  logic        accept;
  logic [15:0] tick_inc;
  logic [10:0] data_len;
  logic [10:0] crc_hi_limit;
  logic [3:0]  verdict;
  logic        crc_mode_fb;

  assign in_ready   = push_ready;
  assign cfg_ready  = 1'b1;
  assign accept     = in_valid && push_ready;
  assign push_valid = in_valid && emit;
  assign push_grp   = grp;

  assign tick_inc     = tick_counter + 16'd1;
  assign data_len     = large_packet ? 11'd1024 : 11'd128;
  assign crc_hi_limit = data_len + (crc_mode ? 11'd3 : 11'd2);
  assign crc_mode_fb  = (start_count >= crc_attempts) ? 1'b0 : crc_mode;

  always_comb begin
    priority if (received_sequence != expected_sequence) verdict = ST_BAD_SEQ;
    else if (complement_bad)                              verdict = ST_BAD_COMPL;
    else if (crc_mode)
      verdict = ({received_crc_high, data_byte} == crc_accumulator) ? ST_GOOD : ST_BAD_CRC;
    else
      verdict = (data_byte == sum_accumulator) ? ST_GOOD : ST_BAD_SUM;
  end

  always_comb begin
    phase_next             = phase;
    expected_sequence_next = expected_sequence;
    crc_mode_next          = crc_mode;
    start_count_next       = start_count;
    byte_position_next     = byte_position;
    large_packet_next      = large_packet;
    crc_accumulator_next   = crc_accumulator;
    sum_accumulator_next   = sum_accumulator;
    received_sequence_next = received_sequence;
    received_crc_high_next = received_crc_high;
    tick_counter_next      = tick_counter;
    in_start_phase_next    = in_start_phase;
    complement_bad_next    = complement_bad;
    emit                   = 1'b0;
    grp                    = '{two: 1'b0, kind0: KIND_TX, byte0: CH_NAK, byte1: CH_NAK,
                               status: ST_NONE};

    if (mode == MODE_START) begin
      // Restart the session from scratch
      phase_next             = PH_HEADER;
      expected_sequence_next = 8'd1;
      crc_mode_next          = 1'b1;
      start_count_next       = 4'd1;
      byte_position_next     = '0;
      large_packet_next      = 1'b0;
      crc_accumulator_next   = '0;
      sum_accumulator_next   = '0;
      received_sequence_next = '0;
      received_crc_high_next = '0;
      tick_counter_next      = '0;
      in_start_phase_next    = 1'b1;
      complement_bad_next    = 1'b0;
      emit                   = 1'b1;
      grp.byte0              = CH_C;
    end else if (phase == PH_IDLE) begin
      emit = 1'b0;
    end else if (mode == MODE_ABORT) begin
      phase_next = PH_IDLE;
      emit       = 1'b1;
      grp.two    = 1'b1;
      grp.byte0  = CH_CAN;
      grp.byte1  = CH_CAN;
      grp.status = ST_ABORTED;
    end else if (mode == MODE_TICK) begin
      if (tick_inc < timeout_ticks && tick_inc != 16'd0) begin
        tick_counter_next = tick_inc;
      end else begin
        tick_counter_next = '0;
        emit              = 1'b1;
        if (phase == PH_BODY) begin
          phase_next = PH_HEADER;
          grp.status = ST_PKT_TIMEOUT;
        end else if (!in_start_phase) begin
          grp.status = ST_HDR_TIMEOUT;
        end else begin
          crc_mode_next = crc_mode_fb;
          if (start_count >= start_attempts) begin
            phase_next = PH_IDLE;
            grp.status = ST_GAVE_UP;
          end else begin
            grp.two    = 1'b1;
            grp.byte1  = crc_mode_fb ? CH_C : CH_NAK;
            grp.status = ST_HDR_TIMEOUT;
            if (start_count != 4'd15) start_count_next = start_count + 4'd1;
          end
        end
      end
    end else if (phase == PH_HEADER) begin
      if (data_byte == CH_EOT) begin
        phase_next          = PH_IDLE;
        in_start_phase_next = 1'b0;
        emit                = 1'b1;
        grp.byte0           = CH_ACK;
        grp.status          = ST_FINISHED;
      end else if (data_byte == CH_SOH || data_byte == CH_STX) begin
        large_packet_next    = (data_byte == CH_STX);
        phase_next           = PH_BODY;
        in_start_phase_next  = 1'b0;
        byte_position_next   = '0;
        crc_accumulator_next = '0;
        sum_accumulator_next = '0;
        complement_bad_next  = 1'b0;
        tick_counter_next    = '0;
      end
    end else begin
      tick_counter_next = '0;
      if (byte_position == 11'd0) begin
        received_sequence_next = data_byte;
        byte_position_next     = byte_position + 11'd1;
      end else if (byte_position == 11'd1) begin
        complement_bad_next = (data_byte != ~expected_sequence);
        byte_position_next  = byte_position + 11'd1;
      end else if (byte_position < data_len + 11'd2) begin
        crc_accumulator_next = crc_update(crc_accumulator, data_byte);
        sum_accumulator_next = sum_accumulator + data_byte;
        byte_position_next   = byte_position + 11'd1;
        emit                 = 1'b1;
        grp.kind0            = KIND_PAYLOAD;
        grp.byte0            = data_byte;
      end else if (byte_position < crc_hi_limit) begin
        received_crc_high_next = data_byte;
        byte_position_next     = byte_position + 11'd1;
      end else begin
        phase_next         = PH_HEADER;
        byte_position_next = '0;
        emit               = 1'b1;
        grp.status         = verdict;
        if (verdict == ST_GOOD) begin
          expected_sequence_next = expected_sequence + 8'd1;
          grp.byte0              = CH_ACK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= TIMEOUT_TICKS_RESET;
      crc_attempts   <= CRC_ATTEMPTS_RESET;
      start_attempts <= START_ATTEMPTS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIMEOUT_TICKS:  timeout_ticks  <= cfg_data;
        CFG_CRC_ATTEMPTS:   crc_attempts   <= cfg_data[3:0];
        CFG_START_ATTEMPTS: start_attempts <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      expected_sequence <= 8'd1;
      crc_mode          <= 1'b1;
      start_count       <= '0;
      byte_position     <= '0;
      large_packet      <= 1'b0;
      crc_accumulator   <= '0;
      sum_accumulator   <= '0;
      received_sequence <= '0;
      received_crc_high <= '0;
      tick_counter      <= '0;
      in_start_phase    <= 1'b1;
      complement_bad    <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      expected_sequence <= expected_sequence_next;
      crc_mode          <= crc_mode_next;
      start_count       <= start_count_next;
      byte_position     <= byte_position_next;
      large_packet      <= large_packet_next;
      crc_accumulator   <= crc_accumulator_next;
      sum_accumulator   <= sum_accumulator_next;
      received_sequence <= received_sequence_next;
      received_crc_high <= received_crc_high_next;
      tick_counter      <= tick_counter_next;
      in_start_phase    <= in_start_phase_next;
      complement_bad    <= complement_bad_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/xpr_queue.sv =====
// Short queue of result groups between the front and back parts.
`default_nettype none
module xpr_queue #(
  parameter int DEPTH = xpr_pkg::XPR_QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire xpr_pkg::grp_t push_grp,
  output logic               head_valid,
  input  wire logic          pop,
  output xpr_pkg::grp_t      head_grp
);
  import xpr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(DEPTH);

  grp_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != FULL);
  assign head_valid = (count != '0);
  assign head_grp   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/xpr_back.sv =====
// Back part: splits result groups into single results in the output register.
`default_nettype none
module xpr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire xpr_pkg::grp_t head_grp,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               kind,
  output logic [7:0]         out_byte,
  output logic [3:0]         status,
  output logic               last
);
  import xpr_pkg::*;

  logic second;
  logic load;
  logic final_one;

  assign load      = !out_valid || out_ready;
  assign final_one = !head_grp.two || second;
  assign pop       = load && head_valid && final_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) second <= !final_one;
    end
  end

  // Payload of the output register
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      kind     <= second ? KIND_TX : head_grp.kind0;
      out_byte <= second ? head_grp.byte1 : head_grp.byte0;
      status   <= head_grp.status;
      last     <= final_one;
    end
  end

endmodule
`default_nettype wire

// ===== sv/xmodem_packet_receiver_core.sv =====
// Top level of the XMODEM packet receiver.
`default_nettype none
// XMODEM receiver with CRC-16 and 1K packets, falling back to the 8-bit sum.
// Each input item (received byte, timer tick, local abort or session start) is
// taken by the front part, which updates the protocol state and the CRC in
// a single step, so items are accepted back to back while the result queue has
// room. An item yields zero, one or two results; the back part hands out one
// result per cycle from its output register while out_ready is high, so an item
// with two results (timeout with restart, abort) is handed out in turn. The queue
// holds QUEUE_DEPTH result groups, which lets the input run on while results
// wait to be taken. Configuration writes are taken at any cycle (cfg_ready is
// always high) and must only be issued while the block is idle.
module xmodem_packet_receiver_core #(
  parameter int QUEUE_DEPTH = xpr_pkg::XPR_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [7:0]       out_byte,
  output logic [3:0]       status,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import xpr_pkg::*;

  logic push_valid, push_ready;
  grp_t push_grp;
  logic head_valid, pop;
  grp_t head_grp;

  xpr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .data_byte  (data_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_grp   (push_grp)
  );

  xpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_grp   (push_grp),
    .head_valid (head_valid),
    .pop        (pop),
    .head_grp   (head_grp)
  );

  xpr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_grp   (head_grp),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .out_byte   (out_byte),
    .status     (status),
    .last       (last)
  );

endmodule
`default_nettype wire

// ===== tb/sv/xmodem_packet_receiver_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the XMODEM packet receiver core.
module xmodem_packet_receiver_core_test;
  import xpr_pkg::*;

  localparam int SETTLE      = 2 * XPR_QUEUE_DEPTH + 6;
  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int REPORT_CAP  = 100;
  localparam int TICK_RUN_CAP = 64;

  // ways of spoiling a packet on purpose
  localparam int FLAW_NONE  = 0;
  localparam int FLAW_SEQ   = 1;
  localparam int FLAW_DUP   = 2;
  localparam int FLAW_COMPL = 3;
  localparam int FLAW_CHECK = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] octet;
    logic [3:0] status;
    logic       last;
  } reply_t;

  // Tracks the receiver session and holds the replies it owes.
  class xmodem_rx_ledger;
    logic [15:0] timeout_ticks;
    logic [3:0]  crc_attempts, start_attempts;
    phase_t      phase;
    logic [7:0]  next_seq, got_seq, got_crc_hi, sum_acc;
    logic [15:0] crc_acc, ticks;
    logic [3:0]  starts;
    int unsigned pos;
    bit          crc_mode, big, opening, compl_bad;
    reply_t      due[$];
    int          faults, replies_seen;

    function new();
      timeout_ticks  = TIMEOUT_TICKS_RESET;
      crc_attempts   = CRC_ATTEMPTS_RESET;
      start_attempts = START_ATTEMPTS_RESET;
      faults         = 0;
      replies_seen   = 0;
      clear_session();
    endfunction

    static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void clear_session();
      phase      = PH_IDLE;
      next_seq   = 8'd1;
      crc_mode   = 1'b1;
      starts     = 4'd0;
      pos        = 0;
      big        = 1'b0;
      crc_acc    = 16'h0000;
      sum_acc    = 8'h00;
      got_seq    = 8'h00;
      got_crc_hi = 8'h00;
      ticks      = 16'h0000;
      opening    = 1'b1;
      compl_bad  = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_TIMEOUT_TICKS:  timeout_ticks  = val;
        CFG_CRC_ATTEMPTS:   crc_attempts   = val[3:0];
        CFG_START_ATTEMPTS: start_attempts = val[3:0];
        default: ;
      endcase
    endfunction

    function void emit(logic k, logic [7:0] b, logic [3:0] st);
      due.push_back('{k, b, st, 1'b0});
    endfunction

    function void on_tick();
      ticks = ticks + 16'd1;
      if (ticks < timeout_ticks && ticks != 16'd0) return;
      ticks = 16'h0000;
      if (phase == PH_BODY) begin
        phase = PH_HEADER;
        emit(KIND_TX, CH_NAK, ST_PKT_TIMEOUT);
        return;
      end
      if (!opening) begin
        emit(KIND_TX, CH_NAK, ST_HDR_TIMEOUT);
        return;
      end
      if (starts >= crc_attempts) crc_mode = 1'b0;
      if (starts >= start_attempts) begin
        phase = PH_IDLE;
        emit(KIND_TX, CH_NAK, ST_GAVE_UP);
        return;
      end
      emit(KIND_TX, CH_NAK, ST_HDR_TIMEOUT);
      emit(KIND_TX, crc_mode ? CH_C : CH_NAK, ST_HDR_TIMEOUT);
      if (starts != 4'd15) starts = starts + 4'd1;
    endfunction

    function void on_byte(logic [7:0] b);
      int unsigned body_len, total;
      logic [3:0]  verdict;
      if (phase == PH_HEADER) begin
        if (b == CH_EOT) begin
          phase   = PH_IDLE;
          opening = 1'b0;
          emit(KIND_TX, CH_ACK, ST_FINISHED);
          return;
        end
        // anything but a header is line noise here
        if (b != CH_SOH && b != CH_STX) return;
        big       = (b == CH_STX);
        phase     = PH_BODY;
        opening   = 1'b0;
        pos       = 0;
        crc_acc   = 16'h0000;
        sum_acc   = 8'h00;
        compl_bad = 1'b0;
        ticks     = 16'h0000;
        return;
      end
      ticks    = 16'h0000;
      body_len = big ? 1024 : 128;
      total    = body_len + (crc_mode ? 4 : 3);
      if (pos == 0) begin
        got_seq = b;
        pos++;
        return;
      end
      if (pos == 1) begin
        compl_bad = (b != (next_seq ^ 8'hFF));
        pos++;
        return;
      end
      if (pos < body_len + 2) begin
        crc_acc = crc_step(crc_acc, b);
        sum_acc = sum_acc + b;
        pos++;
        emit(KIND_PAYLOAD, b, ST_NONE);
        return;
      end
      if (pos + 1 < total) begin
        got_crc_hi = b;
        pos++;
        return;
      end
      phase = PH_HEADER;
      pos   = 0;
      if (got_seq != next_seq) verdict = ST_BAD_SEQ;
      else if (compl_bad) verdict = ST_BAD_COMPL;
      else if (crc_mode) verdict = ({got_crc_hi, b} == crc_acc) ? ST_GOOD : ST_BAD_CRC;
      else verdict = (b == sum_acc) ? ST_GOOD : ST_BAD_SUM;
      if (verdict == ST_GOOD) next_seq = next_seq + 8'd1;
      emit(KIND_TX, (verdict == ST_GOOD) ? CH_ACK : CH_NAK, verdict);
    endfunction

    function void take_event(logic [1:0] m, logic [7:0] b);
      int owed;
      owed = due.size();
      if (m == MODE_START) begin
        clear_session();
        phase  = PH_HEADER;
        starts = 4'd1;
        emit(KIND_TX, CH_C, ST_NONE);
      end else if (phase == PH_IDLE) begin
        // no session: drop the item
      end else if (m == MODE_ABORT) begin
        phase = PH_IDLE;
        emit(KIND_TX, CH_CAN, ST_ABORTED);
        emit(KIND_TX, CH_CAN, ST_ABORTED);
      end else if (m == MODE_TICK) begin
        on_tick();
      end else begin
        on_byte(b);
      end
      if (due.size() > owed) due[due.size() - 1].last = 1'b1;
    endfunction

    function void flag(string field, logic [7:0] want, logic [7:0] got);
      faults++;
      if (faults <= REPORT_CAP) $error("%s: expected %0h, got %0h", field, want, got);
    endfunction

    function void match_reply(logic k, logic [7:0] b, logic [3:0] st, logic l);
      reply_t want;
      replies_seen++;
      if (due.size() == 0) begin
        faults++;
        if (faults <= REPORT_CAP)
          $error("result with nothing pending: kind %0h byte %0h status %0h", k, b, st);
        return;
      end
      want = due.pop_front();
      if (k !== want.kind) flag("kind", want.kind, k);
      if (b !== want.octet) flag("out_byte", want.octet, b);
      if (st !== want.status) flag("status", want.status, st);
      if (l !== want.last) flag("last", want.last, l);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid, in_ready;
  logic [1:0]  mode;
  logic [7:0]  data_byte;
  logic        out_valid, out_ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [3:0]  status;
  logic        last;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  xmodem_rx_ledger ledger;
  int items_in   = 0;
  int hold_left  = 0;
  int quiet      = 0;
  bit hold_long  = 1'b0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  xmodem_packet_receiver_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // result side: check what is taken, then choose the next ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) ledger.match_reply(kind, out_byte, status, last);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_long) begin
        hold_long = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic offer(input logic [1:0] m, input logic [7:0] b);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    ledger.take_event(m, b);
    items_in++;
  endtask

  // hold input, wait for every owed reply, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] t, input logic [3:0] ca, input logic [3:0] sa);
    logic [15:0] vals [3];
    logic [1:0]  idx [3];
    vals = '{t, 16'(ca), 16'(sa)};
    idx  = '{CFG_TIMEOUT_TICKS, CFG_CRC_ATTEMPTS, CFG_START_ATTEMPTS};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      ledger.set_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic feed_block(input bit big_frame, input int flaw, input bit squeeze);
    logic [7:0]  seq, b, sum;
    logic [15:0] crc;
    bit          use_crc;
    int          len;
    use_crc = ledger.crc_mode;
    len     = big_frame ? 1024 : 128;
    seq     = ledger.next_seq;
    crc     = 16'h0000;
    sum     = 8'h00;
    if (flaw == FLAW_SEQ) seq = seq + 8'($urandom_range(1, 254));
    else if (flaw == FLAW_DUP) seq = seq - 8'd1;
    offer(MODE_BYTE, big_frame ? CH_STX : CH_SOH);
    offer(MODE_BYTE, seq);
    b = ~seq;
    if (flaw == FLAW_COMPL) b = b ^ (8'd1 << $urandom_range(0, 7));
    offer(MODE_BYTE, b);
    for (int i = 0; i < len; i++) begin
      if (squeeze && i == len / 4) hold_long = 1'b1;
      b   = 8'($urandom);
      crc = xmodem_rx_ledger::crc_step(crc, b);
      sum = sum + b;
      offer(MODE_BYTE, b);
    end
    if (flaw == FLAW_CHECK) begin
      crc = crc ^ (16'd1 << $urandom_range(0, 15));
      sum = sum ^ (8'd1 << $urandom_range(0, 7));
    end
    if (use_crc) begin
      offer(MODE_BYTE, crc[15:8]);
      offer(MODE_BYTE, crc[7:0]);
    end else begin
      offer(MODE_BYTE, sum);
    end
  endtask

  // ticks up to the next timeout, now and then stopping short
  task automatic tick_run();
    int need;
    if (ledger.ticks < ledger.timeout_ticks)
      need = int'(ledger.timeout_ticks) - int'(ledger.ticks);
    else
      need = 1;
    if (need > TICK_RUN_CAP) need = $urandom_range(1, 8);
    else if (need > 1 && $urandom_range(0, 4) == 0) need = $urandom_range(1, need - 1);
    repeat (need) offer(MODE_TICK, 8'($urandom));
  endtask

  task automatic run_scenarios(input int quota);
    int base, pick, flaw;
    base = items_in;
    while (items_in - base < quota) begin
      pick = $urandom_range(0, 99);
      if (ledger.phase == PH_IDLE) begin
        if (pick < 20) begin
          offer(2'($urandom_range(0, 2)), 8'($urandom));
          base++;  // ignored items do not count
        end else begin
          offer(MODE_START, 8'($urandom));
        end
      end else if (ledger.phase == PH_BODY) begin
        if (pick < 40 && !ledger.big)
          repeat ((ledger.crc_mode ? 132 : 131) - int'(ledger.pos))
            offer(MODE_BYTE, 8'($urandom));
        else if (pick < 75) tick_run();
        else if (pick < 88) offer(MODE_ABORT, 8'($urandom));
        else offer(MODE_START, 8'($urandom));
      end else begin
        if (pick < 40) begin
          flaw = $urandom_range(0, 9);
          if (flaw > FLAW_CHECK) flaw = FLAW_NONE;
          feed_block(1'b0, flaw, 1'b0);
        end else if (pick < 52) begin
          // cut-off packet, left to a later timeout, abort or restart
          offer(MODE_BYTE, ($urandom_range(0, 3) == 0) ? CH_STX : CH_SOH);
          repeat ($urandom_range(0, 12)) offer(MODE_BYTE, 8'($urandom));
        end else if (pick < 72) tick_run();
        else if (pick < 82) repeat ($urandom_range(1, 4)) offer(MODE_BYTE, 8'($urandom));
        else if (pick < 88) offer(MODE_BYTE, CH_EOT);
        else if (pick < 94) offer(MODE_ABORT, 8'($urandom));
        else offer(MODE_START, 8'($urandom));
      end
    end
  endtask

  initial begin
    ledger    = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    mode      = MODE_BYTE;
    data_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = CFG_TIMEOUT_TICKS;
    cfg_data  = 16'h0000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: idle items, noise, finish, restart, abort mid-packet
    offer(MODE_BYTE, CH_SOH);
    offer(MODE_TICK, 8'h00);
    offer(MODE_ABORT, 8'h00);
    offer(MODE_START, 8'h00);
    offer(MODE_BYTE, 8'hFF);
    offer(MODE_BYTE, 8'h00);
    offer(MODE_TICK, 8'hFF);
    offer(MODE_BYTE, CH_EOT);
    offer(MODE_BYTE, 8'h55);
    offer(MODE_START, 8'hFF);
    offer(MODE_START, 8'h00);
    offer(MODE_ABORT, 8'hFF);
    offer(MODE_START, 8'h00);
    offer(MODE_BYTE, CH_SOH);
    offer(MODE_BYTE, 8'h01);
    offer(MODE_BYTE, 8'hFE);
    offer(MODE_BYTE, 8'h00);
    offer(MODE_BYTE, 8'hFF);
    offer(MODE_ABORT, 8'h00);
    drain();

    // shortest limits: fall back to the sum, give up, packet then header timeout
    configure(16'd1, 4'd1, 4'd2);
    offer(MODE_START, 8'h00);
    offer(MODE_TICK, 8'h00);
    offer(MODE_TICK, 8'h00);
    offer(MODE_START, 8'h00);
    offer(MODE_BYTE, CH_STX);
    offer(MODE_TICK, 8'h00);
    offer(MODE_TICK, 8'h00);
    offer(MODE_ABORT, 8'h00);
    drain();

    // two start timeouts push the session into checksum mode
    configure(16'd3, 4'd2, 4'd15);
    offer(MODE_START, 8'h00);
    repeat (6) offer(MODE_TICK, 8'h00);
    run_scenarios(40);
    drain();

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b0;
    configure(16'd1, 4'd15, 4'd1);
    run_scenarios(25);
    drain();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    configure(16'($urandom_range(1, 12)), 4'($urandom_range(1, 15)),
              4'($urandom_range(1, 15)));
    run_scenarios(25);
    drain();

    tx_idle_on = 1'b1;
    configure(16'($urandom_range(2, 40)), 4'($urandom_range(1, 6)),
              4'($urandom_range(4, 15)));
    run_scenarios(25);
    drain();

    // one packet with a long stall on the result side, then a full pause
    configure(16'hFFFF, 4'd15, 4'd15);
    offer(MODE_START, 8'h00);
    feed_block(1'b0, FLAW_NONE, 1'b1);
    drain();
    offer(MODE_BYTE, CH_EOT);
    drain();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    configure(TIMEOUT_TICKS_RESET, CRC_ATTEMPTS_RESET, START_ATTEMPTS_RESET);
    run_scenarios(20);
    drain();

    $display("summary: %0d items sent, %0d results checked, %0d mismatches", items_in,
             ledger.replies_seen, ledger.faults);
    $display("summary: CRC and sum packets, a packet under long stall, timeouts, aborts");
    if (ledger.faults == 0 && ledger.due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
